/* hdl/mssq_pkg.sv */
`default_nettype none
package mssq_pkg;

   localparam logic [10:0]        SAMPLE_DEPTH          = 11'd1024;
   localparam logic signed [31:0] RELAX_DRIVE_MAGNITUDE = 32'sd6554;
   localparam logic signed [31:0] Q_MAX                 = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN                 = 32'sh8000_0000;

   // request kinds
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_STOP  = 2'd2;

   // run modes
   localparam logic [1:0] MODE_STEP_CLOSED = 2'd0;
   localparam logic [1:0] MODE_STEP_BYPASS = 2'd1;
   localparam logic [1:0] MODE_STALL_SCAN  = 2'd2;

   // status codes
   localparam logic [1:0] STATUS_NONE     = 2'd0;
   localparam logic [1:0] STATUS_INVALID  = 2'd1;
   localparam logic [1:0] STATUS_COMPLETE = 2'd2;

   localparam logic [1:0] LOOP_STOPPED = 2'd0;

   // csr indexes
   localparam logic [2:0] CSR_RUN_MODE     = 3'd0;
   localparam logic [2:0] CSR_TARGET_START = 3'd1;
   localparam logic [2:0] CSR_SAMPLE_LIMIT = 3'd2;
   localparam logic [2:0] CSR_END_DRIVE    = 3'd3;
   localparam logic [2:0] CSR_DRIVE_STEP   = 3'd4;
   localparam logic [2:0] CSR_SETTLE_TICKS = 3'd5;
   localparam logic [2:0] CSR_RELAX_TICKS  = 3'd6;
   localparam logic [2:0] CSR_SPARE        = 3'd7;

   typedef struct packed {
      logic [1:0]         run_mode;
      logic signed [31:0] target_or_start_drive;
      logic [10:0]        sample_limit;
      logic signed [31:0] end_drive;
      logic signed [31:0] drive_step;
      logic [19:0]        settle_ticks;
      logic [19:0]        relax_ticks;
   } cfg_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] position;
      logic [15:0]        lvdt_a;
      logic [15:0]        lvdt_b;
   } req_type;

   typedef struct packed {
      logic signed [31:0] setpoint;
      logic               setpoint_valid;
      logic               capture_valid;
      logic [9:0]         capture_index;
      logic signed [31:0] capture_drive;
      logic signed [31:0] capture_position;
      logic [15:0]        capture_lvdt_a;
      logic [15:0]        capture_lvdt_b;
      logic [1:0]         status;
      logic [10:0]        sample_count;
      logic [1:0]         loop_mode;
   } rsp_type;

endpackage
`default_nettype wire

/* hdl/motor_step_and_stall_scan_sequencer.sv */
`default_nettype none
// Test sequencer for a dc motor position loop. Each request is a control tick,
// a start or a stop (kind on req_tuser) and yields exactly one response with
// the setpoint for that tick, an optional telemetry capture, a status code and
// the loop mode. A request is registered on entry, evaluated combinationally
// against the run state and the response is registered on the way out, so
// the block takes one request per clock while responses are accepted; a
// stalled response holds the pipeline only once both input and output registers
// are full. The user must write configuration registers through the csr port
// only while no request is in flight; the block does not enforce it.
module motor_step_and_stall_scan_sequencer (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [63:0]  req_tdata,   // position, lvdt_a, lvdt_b
   input  wire logic [1:0]   req_tuser,   // kind
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // setpoint, capture_index, capture_drive, capture_position, capture_lvdt_a,
   // capture_lvdt_b, sample_count, loop_mode, zero pad
   output logic [151:0]      rsp_tdata,
   output logic [3:0]        rsp_tuser,   // setpoint_valid, capture_valid, status
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_addr,
   input  wire logic [31:0]  csr_wdata
);

   mssq_pkg::cfg_type cfg;
   mssq_pkg::req_type in_ff,  in_in;
   logic              in_vld_ff, in_vld_in;
   mssq_pkg::rsp_type out_ff;
   mssq_pkg::rsp_type rsp_next;
   logic              out_vld_ff, out_vld_in;
   logic              advance;
   logic              req_fire;

   mssq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mssq_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .item    (in_ff),
      .advance (advance),
      .rsp     (rsp_next)
   );

   assign advance    = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_in.kind     = req_tuser;
      in_in.position = $signed(req_tdata[31:0]);
      in_in.lvdt_a   = req_tdata[47:32];
      in_in.lvdt_b   = req_tdata[63:48];
      if (req_fire)
         in_vld_in = 1'b1;
      else if (advance)
         in_vld_in = 1'b0;
      else
         in_vld_in = in_vld_ff;
      if (advance)
         out_vld_in = 1'b1;
      else if (rsp_tready)
         out_vld_in = 1'b0;
      else
         out_vld_in = out_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire)
         in_ff <= in_in;
      if (advance)
         out_ff <= rsp_next;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {1'b0, out_ff.loop_mode, out_ff.sample_count, out_ff.capture_lvdt_b,
                        out_ff.capture_lvdt_a, out_ff.capture_position, out_ff.capture_drive,
                        out_ff.capture_index, out_ff.setpoint};
   assign rsp_tuser  = {out_ff.status, out_ff.capture_valid, out_ff.setpoint_valid};

`ifndef SYNTHESIS
   a_advance_loads_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_vld_ff)
      else $error("evaluated request did not reach the output register");

   a_input_holds: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !advance) |=> (in_vld_ff && $stable(in_ff)))
      else $error("pending request lost or changed while blocked");

   a_complete_stops: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && (out_ff.status == mssq_pkg::STATUS_COMPLETE))
         |-> (out_ff.loop_mode == mssq_pkg::LOOP_STOPPED) && !out_ff.setpoint_valid)
      else $error("finished run still reports an active loop");

   a_no_capture_clean: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !out_ff.capture_valid)
         |-> (out_ff.capture_position == 32'sd0) && (out_ff.capture_index == 10'd0))
      else $error("capture fields set without a capture");

   a_count_only_on_complete: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && (out_ff.status != mssq_pkg::STATUS_COMPLETE))
         |-> (out_ff.sample_count == 11'd0))
      else $error("sample count reported outside capture complete");
`endif

endmodule
`default_nettype wire

/* hdl/mssq_csr.sv */
`default_nettype none
module mssq_csr (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_we,
   input  wire logic [2:0]       csr_addr,
   input  wire logic [31:0]      csr_wdata,
   output mssq_pkg::cfg_type     cfg
);

   mssq_pkg::cfg_type cfg_ff;
   mssq_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            mssq_pkg::CSR_RUN_MODE:     cfg_in.run_mode              = csr_wdata[1:0];
            mssq_pkg::CSR_TARGET_START: cfg_in.target_or_start_drive = csr_wdata;
            mssq_pkg::CSR_SAMPLE_LIMIT: cfg_in.sample_limit          = csr_wdata[10:0];
            mssq_pkg::CSR_END_DRIVE:    cfg_in.end_drive             = csr_wdata;
            mssq_pkg::CSR_DRIVE_STEP:   cfg_in.drive_step            = csr_wdata;
            mssq_pkg::CSR_SETTLE_TICKS: cfg_in.settle_ticks          = csr_wdata[19:0];
            mssq_pkg::CSR_RELAX_TICKS:  cfg_in.relax_ticks           = csr_wdata[19:0];
            mssq_pkg::CSR_SPARE:        cfg_in = cfg_ff;  // reserved, no effect
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.run_mode              <= mssq_pkg::MODE_STEP_CLOSED;
         cfg_ff.target_or_start_drive <= '0;
         cfg_ff.sample_limit          <= 11'd1;
         cfg_ff.end_drive             <= '0;
         cfg_ff.drive_step            <= 32'sd65536;
         cfg_ff.settle_ticks          <= 20'd1;
         cfg_ff.relax_ticks           <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

/* hdl/mssq_core.sv */
`default_nettype none
module mssq_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mssq_pkg::cfg_type cfg,
   input  wire mssq_pkg::req_type item,
   input  wire logic              advance,
   output mssq_pkg::rsp_type      rsp
);

   logic               running_ff,        running_in;
   logic [1:0]         latched_mode_ff,   latched_mode_in;
   logic               relaxing_ff,       relaxing_in;
   logic [10:0]        sample_index_ff,   sample_index_in;
   logic [19:0]        settle_count_ff,   settle_count_in;
   logic [19:0]        relax_count_ff,    relax_count_in;
   logic signed [31:0] current_drive_ff,  current_drive_in;
   logic               relax_negative_ff, relax_negative_in;

   logic [10:0]        lim;
   logic [19:0]        settle_lim;
   logic [10:0]        idx_inc;
   logic [19:0]        settle_inc;
   logic [19:0]        relax_inc;
   logic [32:0]        sum_wide;
   logic signed [31:0] next_drive;
   logic               start_ok;
   logic               done;

   // clamp live limits
   always_comb begin
      if (cfg.sample_limit == 11'd0)
         lim = 11'd1;
      else if (cfg.sample_limit > mssq_pkg::SAMPLE_DEPTH)
         lim = mssq_pkg::SAMPLE_DEPTH;
      else
         lim = cfg.sample_limit;
      settle_lim = (cfg.settle_ticks == 20'd0) ? 20'd1 : cfg.settle_ticks;
   end

   // saturating drive advance
   always_comb begin
      sum_wide = {current_drive_ff[31], current_drive_ff}
               + {cfg.drive_step[31], cfg.drive_step};
      if (sum_wide[32] != sum_wide[31])
         next_drive = sum_wide[32] ? mssq_pkg::Q_MIN : mssq_pkg::Q_MAX;
      else
         next_drive = $signed(sum_wide[31:0]);
   end

   assign start_ok = (cfg.run_mode == mssq_pkg::MODE_STEP_CLOSED)
      || (cfg.run_mode == mssq_pkg::MODE_STEP_BYPASS)
      || ((cfg.run_mode == mssq_pkg::MODE_STALL_SCAN) && (cfg.drive_step != 32'sd0)
          && !((cfg.end_drive > cfg.target_or_start_drive) && (cfg.drive_step < 32'sd0))
          && !((cfg.end_drive < cfg.target_or_start_drive) && (cfg.drive_step > 32'sd0)));

   assign idx_inc    = sample_index_ff + 11'd1;
   assign settle_inc = settle_count_ff + 20'd1;
   assign relax_inc  = relax_count_ff + 20'd1;

   always_comb begin
      running_in        = running_ff;
      latched_mode_in   = latched_mode_ff;
      relaxing_in       = relaxing_ff;
      sample_index_in   = sample_index_ff;
      settle_count_in   = settle_count_ff;
      relax_count_in    = relax_count_ff;
      current_drive_in  = current_drive_ff;
      relax_negative_in = relax_negative_ff;
      done              = 1'b0;
      rsp               = '0;
      rsp.status        = mssq_pkg::STATUS_NONE;

      case (item.kind)
         mssq_pkg::KIND_START: begin
            if (start_ok) begin
               running_in      = 1'b1;
               latched_mode_in = cfg.run_mode;
               sample_index_in = '0;
               settle_count_in = '0;
               relax_count_in  = '0;
               relaxing_in     = 1'b0;
               if (cfg.run_mode == mssq_pkg::MODE_STALL_SCAN) begin
                  current_drive_in  = cfg.target_or_start_drive;
                  relax_negative_in = cfg.drive_step > 32'sd0;
               end
            end else begin
               rsp.status = mssq_pkg::STATUS_INVALID;
            end
         end
         mssq_pkg::KIND_STOP: begin
            running_in = 1'b0;
         end
         mssq_pkg::KIND_TICK: begin
            if (running_ff) begin
               if (latched_mode_ff != mssq_pkg::MODE_STALL_SCAN) begin
                  rsp.setpoint = cfg.target_or_start_drive;
                  if (sample_index_ff >= lim) begin
                     done = 1'b1;
                  end else begin
                     rsp.capture_valid = 1'b1;
                     rsp.capture_index = sample_index_ff[9:0];
                     rsp.capture_drive = cfg.target_or_start_drive;
                     sample_index_in   = idx_inc;
                     if (idx_inc >= lim)
                        done = 1'b1;
                     else
                        rsp.setpoint_valid = 1'b1;
                  end
               end else if (relaxing_ff) begin
                  rsp.setpoint       = relax_negative_ff ? (32'sd0 - mssq_pkg::RELAX_DRIVE_MAGNITUDE)
                                                         : mssq_pkg::RELAX_DRIVE_MAGNITUDE;
                  rsp.setpoint_valid = 1'b1;
                  relax_count_in     = relax_inc;
                  if (relax_inc >= cfg.relax_ticks) begin
                     relax_count_in  = '0;
                     settle_count_in = '0;
                     relaxing_in     = 1'b0;
                  end
               end else begin
                  rsp.setpoint    = current_drive_ff;
                  settle_count_in = settle_inc;
                  if (settle_inc < settle_lim) begin
                     rsp.setpoint_valid = 1'b1;
                  end else begin
                     settle_count_in = '0;
                     if (sample_index_ff < mssq_pkg::SAMPLE_DEPTH) begin
                        rsp.capture_valid = 1'b1;
                        rsp.capture_index = sample_index_ff[9:0];
                        rsp.capture_drive = current_drive_ff;
                        sample_index_in   = idx_inc;
                     end
                     if (((cfg.drive_step > 32'sd0) && (next_drive > cfg.end_drive))
                         || ((cfg.drive_step < 32'sd0) && (next_drive < cfg.end_drive))
                         || (sample_index_in >= mssq_pkg::SAMPLE_DEPTH)) begin
                        done = 1'b1;
                     end else begin
                        rsp.setpoint_valid = 1'b1;
                        current_drive_in   = next_drive;
                        if (cfg.relax_ticks != 20'd0) begin
                           relax_count_in = '0;
                           relaxing_in    = 1'b1;
                        end
                     end
                  end
               end
               if (done) begin
                  running_in = 1'b0;
                  rsp.status = mssq_pkg::STATUS_COMPLETE;
               end
            end
         end
         default: begin
            running_in = running_ff;  // unknown kind leaves the run alone
         end
      endcase

      if (rsp.capture_valid) begin
         rsp.capture_position = item.position;
         rsp.capture_lvdt_a   = item.lvdt_a;
         rsp.capture_lvdt_b   = item.lvdt_b;
      end
      if (done)
         rsp.sample_count = sample_index_in;
      rsp.loop_mode = running_in ? (latched_mode_in + 2'd1) : mssq_pkg::LOOP_STOPPED;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff        <= 1'b0;
         latched_mode_ff   <= mssq_pkg::MODE_STEP_CLOSED;
         relaxing_ff       <= 1'b0;
         sample_index_ff   <= '0;
         settle_count_ff   <= '0;
         relax_count_ff    <= '0;
         current_drive_ff  <= '0;
         relax_negative_ff <= 1'b0;
      end else if (advance) begin
         running_ff        <= running_in;
         latched_mode_ff   <= latched_mode_in;
         relaxing_ff       <= relaxing_in;
         sample_index_ff   <= sample_index_in;
         settle_count_ff   <= settle_count_in;
         relax_count_ff    <= relax_count_in;
         current_drive_ff  <= current_drive_in;
         relax_negative_ff <= relax_negative_in;
      end
   end

endmodule
`default_nettype wire
